// ----- src/wodo_pkg.sv -----
// Shared widths, constants, result types and helper functions for the wheel odometry block.
// All modules but wodo_checker import this package; it depends on nothing else.
package wodo_pkg;

    // Port widths.
    localparam int ANG_W       = 32;
    localparam int CFG_W       = 24;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 96;
    localparam int OUT_W       = 32;
    localparam int MAG_W       = 31;

    // Internal datapath widths.
    localparam int SUM_W       = ANG_W + 1;
    localparam int PROD_W      = SUM_W + CFG_W + 1;
    localparam int FRAC_W      = 16;
    localparam int DIST_W      = PROD_W - FRAC_W;
    localparam int RED_W       = 58;
    localparam int HEAD_W      = 35;
    localparam int Z_W         = 34;
    localparam int GUARD       = 8;
    localparam int XY_W        = 51;
    localparam int RND_W       = XY_W - GUARD;
    localparam int GAIN_W      = 30;
    localparam int DL_W        = 21;
    localparam int DH_W        = DIST_W - DL_W;
    localparam int PH_W        = DH_W + GAIN_W + 1;
    localparam int PL_W        = DL_W + GAIN_W;
    localparam int GSUM_W      = PH_W + DL_W;
    localparam int GAIN_SHIFT  = GAIN_W - GUARD;

    localparam int ROUND_HALF  = 32768;
    localparam int GUARD_HALF  = 128;

    // Heading reduction: a bias that is a multiple of 2*pi makes the product
    // non-negative, then one conditional subtract of 2*pi << k per stage.
    localparam logic [RED_W-1:0] TWO_PI_Q32 = 58'd26986075409;
    localparam logic [RED_W-1:0] RED_BIAS   =
        ((58'd1 << 56) / TWO_PI_Q32 + 58'd1) * TWO_PI_Q32;
    localparam int RED_STEPS = 23;

    localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [GAIN_W-1:0]     GAIN_Q30    = 30'd652032874;

    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 30;
    localparam int CORDIC_N      = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    // Configuration register indexes, decoded from paddr[2].
    localparam logic REG_HALF_WHEEL_RADIUS = 1'b0;
    localparam logic REG_RADIUS_OVER_TRACK = 1'b1;

    localparam logic [CFG_W-1:0] HWR_RESET = 24'd32768;
    localparam logic [CFG_W-1:0] ROT_RESET = 24'd65536;

    // Distance and heading remainder leaving the front end and the reduction stages.
    typedef struct packed {
        logic signed [DIST_W-1:0] travel;
        logic [RED_W-1:0]         rem;
    } red_t;

    // Rotated vector at guard precision, before rounding.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [MAG_W-1:0]       mag;
        logic                   mag_sat;
    } vec_t;

    // Finished result beat.
    typedef struct packed {
        logic [MAG_W-1:0]        radius_vector;
        logic signed [OUT_W-1:0] pos_y;
        logic signed [OUT_W-1:0] pos_x;
        logic                    saturated;
    } res_t;

    function automatic logic [RED_W-1:0] red_sub(input int k);
        return TWO_PI_Q32 << k;
    endfunction

    // atan(2^-i) in Q.30, floored.
    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            0: r = 34'sd843314856;
            1: r = 34'sd497837829;
            2: r = 34'sd263043836;
            3: r = 34'sd133525158;
            4: r = 34'sd67021686;
            5: r = 34'sd33543515;
            6: r = 34'sd16775850;
            7: r = 34'sd8388437;
            8: r = 34'sd4194282;
            9: r = 34'sd2097149;
            default: r = Z_W'((64'sd1 <<< (30 - idx)) - 64'sd1);
        endcase
        return r;
    endfunction

endpackage

// ----- src/wodo_front.sv -----
// Front end: wheel angle sum and difference, the two configuration multiplies,
// distance rounding and biasing of the heading product. Uses wodo_pkg.
module wodo_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [wodo_pkg::ANG_W-1:0]   left_angle,
    input  logic signed [wodo_pkg::ANG_W-1:0]   right_angle,
    input  logic [wodo_pkg::CFG_W-1:0]          half_wheel_radius,
    input  logic [wodo_pkg::CFG_W-1:0]          radius_over_track,
    output logic                                out_valid,
    output wodo_pkg::red_t                      out_data
);
    import wodo_pkg::*;

    logic [2:0]               v_reg;
    logic [2:0]               v_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  diff_reg;
    logic signed [SUM_W-1:0]  diff_next;
    logic signed [PROD_W-1:0] dprod_reg;
    logic signed [PROD_W-1:0] dprod_next;
    logic signed [PROD_W-1:0] hprod_reg;
    logic signed [PROD_W-1:0] hprod_next;
    logic signed [PROD_W-1:0] rounded;
    red_t                     st3_reg;
    red_t                     st3_next;

    always_comb begin
        v_next     = {v_reg[1:0], in_valid};
        sum_next   = SUM_W'(left_angle) + SUM_W'(right_angle);
        diff_next  = SUM_W'(right_angle) - SUM_W'(left_angle);
        dprod_next = sum_reg * $signed({1'b0, half_wheel_radius});
        hprod_next = diff_reg * $signed({1'b0, radius_over_track});
        rounded    = dprod_reg + PROD_W'(ROUND_HALF);
        st3_next.travel = DIST_W'(rounded >>> FRAC_W);
        // The bias is a multiple of 2*pi, so the remainder is unchanged and never negative.
        st3_next.rem  = RED_W'(hprod_reg) + RED_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= sum_next;
            diff_reg  <= diff_next;
            dprod_reg <= dprod_next;
            hprod_reg <= hprod_next;
            st3_reg   <= st3_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = st3_reg;

endmodule

// ----- src/wodo_modred.sv -----
// Heading reduction modulo 2*pi: one restoring compare and subtract stage per
// quotient bit, with the distance carried alongside. Uses wodo_pkg.
module wodo_modred (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  wodo_pkg::red_t in_data,
    output logic           out_valid,
    output wodo_pkg::red_t out_data
);
    import wodo_pkg::*;

    logic [RED_STEPS-1:0] v_reg;
    logic [RED_STEPS-1:0] v_next;
    red_t                 st_reg [RED_STEPS];
    red_t                 st_next [RED_STEPS];
    red_t                 src [RED_STEPS];

    always_comb begin
        v_next = {v_reg[RED_STEPS-2:0], in_valid};
        src[0] = in_data;
        for (int s = 1; s < RED_STEPS; s++) begin
            src[s] = st_reg[s-1];
        end
        // The largest multiple is taken off first.
        for (int s = 0; s < RED_STEPS; s++) begin
            st_next[s] = src[s];
            if (src[s].rem >= red_sub(RED_STEPS - 1 - s)) begin
                st_next[s].rem = src[s].rem - red_sub(RED_STEPS - 1 - s);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < RED_STEPS; s++) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign out_valid = v_reg[RED_STEPS-1];
    assign out_data  = st_reg[RED_STEPS-1];

endmodule

// ----- src/wodo_cordic.sv -----
// Quadrant fold, gain correction and the pipelined CORDIC rotation, one
// stage per iteration, ending in the fold sign correction. Uses wodo_pkg.
module wodo_cordic (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  wodo_pkg::red_t in_data,
    output logic           out_valid,
    output wodo_pkg::vec_t out_data
);
    import wodo_pkg::*;

    typedef struct packed {
        logic signed [Z_W-1:0]  z;
        logic                   neg;
        logic signed [PH_W-1:0] ph;
        logic [PL_W-1:0]        pl;
        logic [MAG_W-1:0]       mag;
        logic                   mag_sat;
    } fold_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
        logic [MAG_W-1:0]       mag;
        logic                   mag_sat;
    } cord_t;

    localparam int NV = CORDIC_N + 3;

    logic [NV-1:0]              v_reg;
    logic [NV-1:0]              v_next;
    fold_t                      fold_reg;
    fold_t                      fold_next;
    cord_t                      gain_reg;
    cord_t                      gain_next;
    cord_t                      c_reg [CORDIC_N];
    cord_t                      c_next [CORDIC_N];
    cord_t                      c_src [CORDIC_N];
    vec_t                       neg_reg;
    vec_t                       neg_next;
    logic signed [Z_W-1:0]      z0;
    logic signed [Z_W-1:0]      z1;
    logic signed [DIST_W-1:0]   abs_d;
    logic signed [GSUM_W-1:0]   gsum;
    logic signed [XY_W-1:0]     dx;
    logic signed [XY_W-1:0]     dy;
    cord_t                      last;

    // Fold stage: heading to [-pi/2, pi/2], gain partial products, magnitude.
    always_comb begin
        z0 = $signed({1'b0, in_data.rem[HEAD_W-1:2]});
        z1 = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 : z0;
        fold_next.z   = z1;
        fold_next.neg = 1'b0;
        if (z1 > HALF_PI_Q30) begin
            fold_next.z   = z1 - PI_Q30;
            fold_next.neg = 1'b1;
        end else if (z1 < -HALF_PI_Q30) begin
            fold_next.z   = z1 + PI_Q30;
            fold_next.neg = 1'b1;
        end
        fold_next.ph = $signed(in_data.travel[DIST_W-1:DL_W]) * $signed({1'b0, GAIN_Q30});
        fold_next.pl = in_data.travel[DL_W-1:0] * GAIN_Q30;
        abs_d = (in_data.travel < 0) ? -in_data.travel : in_data.travel;
        fold_next.mag_sat = (abs_d > DIST_W'({MAG_W{1'b1}}));
        fold_next.mag     = fold_next.mag_sat ? {MAG_W{1'b1}} : abs_d[MAG_W-1:0];
    end

    // Gain stage: recombine the partial products into distance*K with guard bits.
    always_comb begin
        gsum = (GSUM_W'(fold_reg.ph) <<< DL_W) + GSUM_W'($signed({1'b0, fold_reg.pl}));
        gain_next.x       = XY_W'(gsum >>> GAIN_SHIFT);
        gain_next.y       = '0;
        gain_next.z       = fold_reg.z;
        gain_next.neg     = fold_reg.neg;
        gain_next.mag     = fold_reg.mag;
        gain_next.mag_sat = fold_reg.mag_sat;
    end

    always_comb begin
        c_src[0] = gain_reg;
        for (int i = 1; i < CORDIC_N; i++) begin
            c_src[i] = c_reg[i-1];
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = c_src[i].y >>> i;
            dy = c_src[i].x >>> i;
            c_next[i] = c_src[i];
            if (c_src[i].z >= 0) begin
                c_next[i].x = c_src[i].x - dx;
                c_next[i].y = c_src[i].y + dy;
                c_next[i].z = c_src[i].z - atan_q30(i);
            end else begin
                c_next[i].x = c_src[i].x + dx;
                c_next[i].y = c_src[i].y - dy;
                c_next[i].z = c_src[i].z + atan_q30(i);
            end
        end
    end

    // A fold by pi turns the vector around.
    always_comb begin
        last             = c_reg[CORDIC_N-1];
        neg_next.x       = last.neg ? -last.x : last.x;
        neg_next.y       = last.neg ? -last.y : last.y;
        neg_next.mag     = last.mag;
        neg_next.mag_sat = last.mag_sat;
        v_next           = {v_reg[NV-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_reg <= fold_next;
            gain_reg <= gain_next;
            for (int i = 0; i < CORDIC_N; i++) begin
                c_reg[i] <= c_next[i];
            end
            neg_reg <= neg_next;
        end
    end

    assign out_valid = v_reg[NV-1];
    assign out_data  = neg_reg;

endmodule

// ----- src/wodo_out.sv -----
// Output stage: rounding and saturation to Q16.16, the output register and a
// one-beat skid register that sets the pipeline enable. Uses wodo_pkg.
module wodo_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  wodo_pkg::vec_t in_data,
    input  logic           m_ready,
    output logic           en,
    output logic           m_valid,
    output wodo_pkg::res_t m_data
);
    import wodo_pkg::*;

    logic signed [RND_W-1:0] xr;
    logic signed [RND_W-1:0] yr;
    logic                    x_hi;
    logic                    x_lo;
    logic                    y_hi;
    logic                    y_lo;
    res_t                    res;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    res_t                    out_reg;
    res_t                    out_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    res_t                    skid_reg;
    res_t                    skid_next;

    always_comb begin
        xr   = RND_W'((in_data.x + XY_W'(GUARD_HALF)) >>> GUARD);
        yr   = RND_W'((in_data.y + XY_W'(GUARD_HALF)) >>> GUARD);
        x_hi = xr > RND_W'(64'sh7FFFFFFF);
        x_lo = xr < -RND_W'(64'sh80000000);
        y_hi = yr > RND_W'(64'sh7FFFFFFF);
        y_lo = yr < -RND_W'(64'sh80000000);
        res.pos_x = x_hi ? 32'sh7FFFFFFF : (x_lo ? 32'sh80000000 : xr[OUT_W-1:0]);
        res.pos_y = y_hi ? 32'sh7FFFFFFF : (y_lo ? 32'sh80000000 : yr[OUT_W-1:0]);
        res.radius_vector = in_data.mag;
        res.saturated     = x_hi | x_lo | y_hi | y_lo | in_data.mag_sat;
    end

    // The pipeline runs while the skid register is free, so one more beat can
    // always land there when the receiver stalls.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_valid_next = in_valid;
            out_next       = res;
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign en      = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- src/wheel_odometry_position_top.sv -----
// Top level of the wheel odometry block: configuration registers and the
// pipeline of wodo_front, wodo_modred, wodo_cordic and wodo_out. Uses wodo_pkg.
//
// Usage:
//   Each input beat on the s_ channel carries one pair of cumulative wheel
//   angles; each produces exactly one result beat on the m_ channel with the
//   X and Y position, the radius vector and a saturation flag. Samples are
//   independent; nothing is integrated between beats.
//   The result passes through 3 front-end stages, 23 heading reduction
//   stages, fold, gain, the CORDIC stages, sign fix and the output
//   register. Throughput is one beat per cycle while s_tready is high.
//   If the receiver stalls, the output register holds its beat and one more
//   beat drains into a skid register; only then does s_tready drop and the
//   whole pipeline freeze. s_tready returns the cycle after the skid beat moves.
//   Reset clears all valid bits and loads half_wheel_radius = 0.5 and
//   radius_over_track = 1.0. The user must write registers over the APB port
//   only while the block is idle; it is not enforced. A read returns the value.
module wheel_odometry_position_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wodo_pkg::PADDR_W-1:0]      paddr,
    input  logic [wodo_pkg::PDATA_W-1:0]      pwdata,
    output logic [wodo_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: left_angle [31:0], right_angle [63:32]
    input  logic [wodo_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: pos_x [31:0], pos_y [63:32], radius_vector [94:64], zero [95]
    output logic [wodo_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: saturated
    output logic                              m_tuser
);
    import wodo_pkg::*;

    logic [CFG_W-1:0] hwr_reg;
    logic [CFG_W-1:0] hwr_next;
    logic [CFG_W-1:0] rot_reg;
    logic [CFG_W-1:0] rot_next;
    logic             en;
    logic             f_valid;
    red_t             f_data;
    logic             r_valid;
    red_t             r_data;
    logic             c_valid;
    vec_t             c_data;
    res_t             res;

    always_comb begin
        hwr_next = hwr_reg;
        rot_next = rot_reg;
        if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_HALF_WHEEL_RADIUS: hwr_next = pwdata[CFG_W-1:0];
                REG_RADIUS_OVER_TRACK: rot_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
        case (paddr[2])
            REG_HALF_WHEEL_RADIUS: prdata = PDATA_W'(hwr_reg);
            REG_RADIUS_OVER_TRACK: prdata = PDATA_W'(rot_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hwr_reg <= HWR_RESET;
            rot_reg <= ROT_RESET;
        end else begin
            hwr_reg <= hwr_next;
            rot_reg <= rot_next;
        end
    end

    assign pready = 1'b1;

    wodo_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .in_valid          (s_tvalid),
        .left_angle        ($signed(s_tdata[ANG_W-1:0])),
        .right_angle       ($signed(s_tdata[2*ANG_W-1:ANG_W])),
        .half_wheel_radius (hwr_reg),
        .radius_over_track (rot_reg),
        .out_valid         (f_valid),
        .out_data          (f_data)
    );

    wodo_modred u_modred (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (r_valid),
        .out_data  (r_data)
    );

    wodo_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_data   (r_data),
        .out_valid (c_valid),
        .out_data  (c_data)
    );

    wodo_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (c_valid),
        .in_data  (c_data),
        .m_ready  (m_tready),
        .en       (en),
        .m_valid  (m_tvalid),
        .m_data   (res)
    );

    assign s_tready = en;
    assign m_tdata  = {1'b0, res.radius_vector, res.pos_y, res.pos_x};
    assign m_tuser  = res.saturated;

endmodule

// ----- src/wodo_checker.sv -----
// Port-level checks of the wheel odometry block's flow control, bound to the
// top level. Depends only on the top-level ports.
module wodo_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    // Reset leaves the block empty and ready for a beat.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("block not empty and ready after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

    // The input side only closes while a result is waiting.
    a_ready_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result waiting");

    // The input side closes only after the receiver stalled a result.
    a_ready_falls_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready dropped without an output stall");

    // One accepted result frees the skid beat and reopens the input side.
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && m_tready) |=> s_tready)
        else $error("s_tready did not return after the skid beat moved");

endmodule

bind wheel_odometry_position_top wodo_checker u_wodo_checker (.*);

// ----- bench/wheel_odometry_position_top_tb.sv -----
// Self-checking bench for wheel_odometry_position_top: directed table, then random samples.
// Needs wodo_pkg and the block's RTL; results are checked against table values or a built-in predictor.
`timescale 1ns / 1ps

module wheel_odometry_position_top_tb;
    import wodo_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_HWR = {REG_HALF_WHEEL_RADIUS, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_ROT = {REG_RADIUS_OVER_TRACK, 2'b00};

    localparam logic signed [31:0] ANG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ANG_MIN = 32'sh8000_0000;

    // Fixed-point constants of the odometry arithmetic.
    localparam longint TURN_Q32      = 64'sd26986075409;
    localparam longint TURN_Q30      = 64'sd6746518852;
    localparam longint HALF_TURN_Q30 = 64'sd3373259426;
    localparam longint QUARTER_Q30   = 64'sd1686629713;
    localparam longint CORDIC_K_Q30  = 64'sd652032874;
    localparam longint Q16_MAX       = 64'sd2147483647;
    localparam longint Q16_MIN       = -64'sd2147483648;
    localparam int     ROT_STAGES    = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;

    typedef struct {
        logic [31:0]        hwr_raw;
        logic [31:0]        rot_raw;
        logic signed [31:0] left;
        logic signed [31:0] right;
        bit                 known;
        res_t               want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;  // left_angle [31:0], right_angle [63:32]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;  // pos_x [31:0], pos_y [63:32], radius_vector [94:64], zero [95]
    logic                  m_tuser;  // saturated

    logic [CFG_W-1:0] hwr_q = 24'h008000;
    logic [CFG_W-1:0] rot_q = 24'h010000;
    res_t             position_q[$];
    stim_row_t        stim_rows[$];
    int               mismatch_count = 0;
    int               send_idle_pct  = 31;
    int               recv_idle_pct  = 62;

    wheel_odometry_position_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint arctan_step(input int i);
        longint a;
        case (i)
            0: a = 843314856;
            1: a = 497837829;
            2: a = 263043836;
            3: a = 133525158;
            4: a = 67021686;
            5: a = 33543515;
            6: a = 16775850;
            7: a = 8388437;
            8: a = 4194282;
            9: a = 2097149;
            default: a = (longint'(1) << (30 - i)) - 1;
        endcase
        return a;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > Q16_MAX) return Q16_MAX;
        if (v < Q16_MIN) return Q16_MIN;
        return v;
    endfunction

    // Position for one pair of wheel angles under the current register values.
    function automatic res_t predict_position(input logic signed [31:0] left, right);
        longint travel, head, z, x, y, dx, dy, gh, gl, rx, ry, cx, cy, mag;
        bit     flip, clip;
        res_t   r;
        flip = 1'b0;
        clip = 1'b0;
        r    = '0;
        travel = ((longint'(left) + longint'(right)) * longint'(hwr_q) + 32768) >>> 16;
        head = ((longint'(right) - longint'(left)) * longint'(rot_q)) % TURN_Q32;
        if (head < 0) head += TURN_Q32;
        z = head >>> 2;
        if (z > HALF_TURN_Q30) z -= TURN_Q30;
        // Fold into the right half plane; a half turn flips the sign of the vector.
        if (z > QUARTER_Q30) begin
            z -= HALF_TURN_Q30;
            flip = 1'b1;
        end else if (z < -QUARTER_Q30) begin
            z += HALF_TURN_Q30;
            flip = 1'b1;
        end
        // Start vector is travel*K with 8 guard bits, split to keep the product exact.
        gh = travel >>> 16;
        gl = travel - gh * 65536;
        x  = (gh * CORDIC_K_Q30 + ((gl * CORDIC_K_Q30) >>> 16)) >>> 6;
        y  = 0;
        for (int i = 0; i < ROT_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_step(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_step(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        rx = (x + 128) >>> 8;
        ry = (y + 128) >>> 8;
        cx = clamp32(rx);
        cy = clamp32(ry);
        clip = (cx != rx) || (cy != ry);
        mag = (travel < 0) ? -travel : travel;
        if (mag > Q16_MAX) begin
            mag  = Q16_MAX;
            clip = 1'b1;
        end
        r.pos_x         = cx[31:0];
        r.pos_y         = cy[31:0];
        r.radius_vector = mag[30:0];
        r.saturated     = clip;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: random back-pressure, every beat checked against the oldest expectation.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (position_q.size() == 0) begin
                $error("result beat with no expectation pending");
                mismatch_count++;
            end else begin
                want = position_q.pop_front();
                check_field("pos_x", want.pos_x, m_tdata[31:0]);
                check_field("pos_y", want.pos_y, m_tdata[63:32]);
                check_field("radius_vector", {1'b0, want.radius_vector}, {1'b0, m_tdata[94:64]});
                check_field("saturated", {31'd0, want.saturated}, {31'd0, m_tuser});
            end
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_sample(input logic signed [31:0] left, right, input res_t want);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        position_q.insert(position_q.size(), want);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (position_q.size() != 0) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with the pipeline empty; both are read back afterwards.
    task automatic apply_settings(input logic [31:0] hw_raw, ro_raw);
        logic [31:0] got;
        drain_results();
        reg_write(ADDR_HWR, hw_raw);
        reg_write(ADDR_ROT, ro_raw);
        hwr_q = hw_raw[CFG_W-1:0];
        rot_q = ro_raw[CFG_W-1:0];
        reg_read(ADDR_HWR, got);
        check_field("half_wheel_radius", {8'd0, hwr_q}, got);
        reg_read(ADDR_ROT, got);
        check_field("radius_over_track", {8'd0, rot_q}, got);
    endtask

    task automatic add_row(input logic [31:0] hw_raw, ro_raw,
                           input logic signed [31:0] left, right, input bit known,
                           input logic [31:0] wx, wy, input logic [30:0] wmag, input bit wsat);
        stim_row_t row;
        row.hwr_raw              = hw_raw;
        row.rot_raw              = ro_raw;
        row.left                 = left;
        row.right                = right;
        row.known                = known;
        row.want.pos_x           = wx;
        row.want.pos_y           = wy;
        row.want.radius_vector   = wmag;
        row.want.saturated       = wsat;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    function automatic logic signed [31:0] corner_angle();
        case ($urandom_range(0, 4))
            0: return ANG_MAX;
            1: return ANG_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    initial begin
        stim_row_t          row;
        res_t               want;
        logic [31:0]        got;
        logic [31:0]        hw;
        logic [31:0]        ro;
        logic signed [31:0] l;
        logic signed [31:0] r;
        int                 pick;

        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        // Reset register values: a zero sum or a zero half radius gives a zero result.
        add_row(32'h0000_8000, 32'h0001_0000, 0, 0, 1, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, ANG_MAX, ANG_MAX, 0, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, ANG_MIN, ANG_MIN, 0, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, ANG_MIN, ANG_MAX, 1, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, ANG_MAX, ANG_MIN, 1, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, 0, 102944, 0, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, 0, 205887, 0, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, 0, -102944, 0, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, 0, 411775, 0, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, 65536, 0, 0, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, -1, 1, 1, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, 1, 1, 0, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, 32'sh5555_5555, 32'sh2AAA_AAAA, 0, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, 32'shAAAA_AAAA, 32'shD555_5555, 0, 0, 0, 0, 0);
        // Upper register bits are dropped on write.
        add_row(32'hFF00_0000, 32'hFFFF_FFFF, 12345, -98765, 1, 0, 0, 0, 0);
        add_row(32'hFF00_0000, 32'hFFFF_FFFF, ANG_MAX, ANG_MIN, 1, 0, 0, 0, 0);
        add_row(32'h00FF_FFFF, 32'h0000_0000, ANG_MAX, ANG_MAX, 0, 0, 0, 0, 0);
        add_row(32'h00FF_FFFF, 32'h0000_0000, ANG_MIN, ANG_MIN, 0, 0, 0, 0, 0);
        add_row(32'h00FF_FFFF, 32'h0000_0000, 32'sh1234_5678, -32'sh0ABC_DEF0, 0, 0, 0, 0, 0);
        add_row(32'h00FF_FFFF, 32'h00FF_FFFF, ANG_MIN, ANG_MAX, 0, 0, 0, 0, 0);
        add_row(32'h00FF_FFFF, 32'h00FF_FFFF, ANG_MAX, 0, 0, 0, 0, 0, 0);
        add_row(32'h0000_1000, 32'h0001_2345, -300000, 4500000, 0, 0, 0, 0, 0);
        add_row(32'h0000_0000, 32'h0000_0000, ANG_MAX, ANG_MAX, 1, 0, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0001_0000, 1000000, 2000000, 0, 0, 0, 0, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        reg_read(ADDR_HWR, got);
        check_field("half_wheel_radius", 32'h0000_8000, got);
        reg_read(ADDR_ROT, got);
        check_field("radius_over_track", 32'h0001_0000, got);

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.hwr_raw[CFG_W-1:0] != hwr_q || row.rot_raw[CFG_W-1:0] != rot_q)
                apply_settings(row.hwr_raw, row.rot_raw);
            want = row.known ? row.want : predict_position(row.left, row.right);
            send_sample(row.left, row.right, want);
        end

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0, 5: begin
                    hw = $urandom_range(0, 32'h0002_0000);
                    ro = $urandom_range(0, 32'h0004_0000);
                end
                1: begin
                    hw = 32'h00FF_FFFF;
                    ro = 32'h00FF_FFFF;
                end
                2: begin
                    hw = $urandom;
                    ro = $urandom;
                end
                3: begin
                    hw = 32'h0000_0000;
                    ro = $urandom;
                end
                default: begin
                    hw = $urandom;
                    ro = 32'h0000_0000;
                end
            endcase
            send_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 62 : 0;
            recv_idle_pct = (phase < 2) ? 62 : (phase < 4) ? 31 : 0;
            apply_settings(hw, ro);
            for (int n = 0; n < 92; n++) begin
                // Let the pipeline run dry once in the middle of a busy phase.
                if (phase == 5 && n == 46)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    l = $urandom;
                    r = $urandom;
                end else if (pick < 60) begin
                    l = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                    r = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                end else if (pick < 85) begin
                    // Nearly straight travel: both wheels turned by about the same angle.
                    l = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
                    r = l + $signed($urandom_range(0, 2000)) - 32'sd1000;
                end else begin
                    l = corner_angle();
                    r = corner_angle();
                end
                send_sample(l, r, predict_position(l, r));
            end
        end

        drain_results();
        repeat (64) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/wodo_pkg.sv
src/wodo_front.sv
src/wodo_modred.sv
src/wodo_cordic.sv
src/wodo_out.sv
src/wheel_odometry_position_top.sv
src/wodo_checker.sv
bench/wheel_odometry_position_top_tb.sv
